// ===== src/hrs_pkg.sv =====
// ----------------------------------------------------------------------------
// hrs_pkg
// Shared widths, register codes and structs of the weighted histogram with
// running statistics.
// ----------------------------------------------------------------------------
`default_nettype none

package hrs_pkg;

    // Field widths
    localparam int SAMPLE_W = 32;
    localparam int WEIGHT_W = 16;
    localparam int COUNT_W  = 32;
    localparam int SUM_W    = 64;
    localparam int SQSUM_W  = 63;
    localparam int DPROD_W  = 48;   // sample * weight
    localparam int SQQ_W    = 47;   // (sample * sample) >> 16
    localparam int QPROD_W  = 63;   // squared term * weight
    localparam int BINOUT_W = 10;
    localparam int NBINS_W  = 11;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_SCALE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_BINS  = 2'd2;

    // Reset values
    localparam logic [31:0]        BIN_SCALE_RST = 32'h0001_0000;
    localparam logic [NBINS_W-1:0] NUM_BINS_RST  = 11'd1024;
    localparam logic [SQSUM_W-1:0] SQ_MAX        = {SQSUM_W{1'b1}};

    // One update of the running statistics
    typedef struct packed {
        logic                       en;
        logic signed [SAMPLE_W-1:0] sample;
        logic [WEIGHT_W-1:0]        weight;
        logic signed [DPROD_W-1:0]  d_prod;
        logic [QPROD_W-1:0]         q_prod;
    } stat_upd_t;

    // Running statistics as seen on the result port
    typedef struct packed {
        logic [COUNT_W-1:0]         item_count;
        logic signed [SUM_W-1:0]    value_sum;
        logic [SQSUM_W-1:0]         square_sum;
        logic signed [SAMPLE_W-1:0] min_value;
        logic signed [SAMPLE_W-1:0] max_value;
    } stat_t;

endpackage

`default_nettype wire

// ===== src/hrs_bin_ram.sv =====
// ----------------------------------------------------------------------------
// hrs_bin_ram
// Bin counter store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module hrs_bin_ram
    import hrs_pkg::*;
#(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
)
(
    input  wire logic               clk,
    input  wire logic               we,
    input  wire logic [ADDR_W-1:0]  waddr,
    input  wire logic [COUNT_W-1:0] wdata,
    input  wire logic               re,
    input  wire logic [ADDR_W-1:0]  raddr,
    output logic [COUNT_W-1:0]      rdata
);

    logic [COUNT_W-1:0] mem [DEPTH];
    logic [COUNT_W-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered read data
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== src/hrs_stats.sv =====
// ----------------------------------------------------------------------------
// hrs_stats
// Running statistics: total weight, weighted sum, weighted sum of squares,
// minimum and maximum, all saturating where they can overflow.
// ----------------------------------------------------------------------------
`default_nettype none

module hrs_stats
    import hrs_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire stat_upd_t upd,
    output stat_t          stats
);

    logic [COUNT_W-1:0]         weight_reg, weight_next;
    logic signed [SUM_W-1:0]    sum_reg, sum_next;
    logic [SQSUM_W-1:0]         sq_reg, sq_next;
    logic signed [SAMPLE_W-1:0] min_reg, min_next;
    logic signed [SAMPLE_W-1:0] max_reg, max_next;

    logic [COUNT_W:0]           weight_add;
    logic [SUM_W:0]             sum_add;
    logic [SQSUM_W:0]           sq_add;

    // Saturating adders
    always_comb
    begin
        weight_add = {1'b0, weight_reg} + {{(COUNT_W + 1 - WEIGHT_W){1'b0}}, upd.weight};
        sum_add    = {sum_reg[SUM_W-1], sum_reg}
                   + {{(SUM_W + 1 - DPROD_W){upd.d_prod[DPROD_W-1]}}, upd.d_prod};
        sq_add     = {1'b0, sq_reg} + {1'b0, upd.q_prod};

        weight_next = weight_add[COUNT_W] ? {COUNT_W{1'b1}} : weight_add[COUNT_W-1:0];

        // overflow when the two top bits of the wide sum disagree
        if (sum_add[SUM_W] != sum_add[SUM_W-1])
        begin
            sum_next = sum_add[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                      : {1'b0, {(SUM_W-1){1'b1}}};
        end
        else
        begin
            sum_next = sum_add[SUM_W-1:0];
        end

        sq_next  = sq_add[SQSUM_W] ? SQ_MAX : sq_add[SQSUM_W-1:0];
        min_next = (upd.sample < min_reg) ? upd.sample : min_reg;
        max_next = (upd.sample > max_reg) ? upd.sample : max_reg;
    end

    // State
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg <= '0;
            sum_reg    <= '0;
            sq_reg     <= '0;
            min_reg    <= {1'b0, {(SAMPLE_W-1){1'b1}}};
            max_reg    <= {1'b1, {(SAMPLE_W-1){1'b0}}};
        end
        else if (upd.en)
        begin
            weight_reg <= weight_next;
            sum_reg    <= sum_next;
            sq_reg     <= sq_next;
            min_reg    <= min_next;
            max_reg    <= max_next;
        end
    end

    assign stats.item_count = weight_reg;
    assign stats.value_sum  = sum_reg;
    assign stats.square_sum = sq_reg;
    assign stats.min_value  = min_reg;
    assign stats.max_value  = max_reg;

endmodule

`default_nettype wire

// ===== src/histogram_with_running_stats_top.sv =====
// Flow: an accepted item passes the multiply, bin RAM read and bin update
//   and write back states before out_valid; out_stall holds the update.
// Items: the read-modify-write sequence on the single bin RAM takes one item
//   at a time; the next item is taken once the previous leaves.
// Reset: after rst_n the bin RAM is cleared one entry a cycle for NUM_BINS
//   cycles with in_stall high; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
// histogram_with_running_stats_top
// Weighted histogram of Q16.16 samples with running weight, sum, sum of
// squares, minimum and maximum.
// ----------------------------------------------------------------------------
`default_nettype none

module histogram_with_running_stats_top
    import hrs_pkg::*;
#(
    parameter int NUM_BINS = 1024
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // configuration
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [31:0]                cfg_data,
    // sample items
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic signed [SAMPLE_W-1:0] sample,
    input  wire logic [WEIGHT_W-1:0]        weight,
    // result items
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic [BINOUT_W-1:0]             bin_index,
    output logic                            in_range,
    output logic [COUNT_W-1:0]              bin_count,
    output logic [COUNT_W-1:0]              item_count,
    output logic signed [SUM_W-1:0]         value_sum,
    output logic [SQSUM_W-1:0]              square_sum,
    output logic signed [SAMPLE_W-1:0]      min_value,
    output logic signed [SAMPLE_W-1:0]      max_value
);

    localparam int          BIN_W     = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam logic [31:0] BIN_LIMIT = 32'(NUM_BINS);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_MUL   = 3'd2;
    localparam logic [2:0] ST_READ  = 3'd3;
    localparam logic [2:0] ST_UPD   = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [BIN_W-1:0] clr_addr_reg, clr_addr_next;

    // configuration registers
    logic signed [31:0]   bin_start_reg;
    logic [31:0]          bin_scale_reg;
    logic [NBINS_W-1:0]   num_bins_reg;

    // item pipeline registers
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic [WEIGHT_W-1:0]        weight_reg;
    logic                       neg_reg;
    logic [31:0]                bin_reg;
    logic [SQQ_W-1:0]           sqq_reg;
    logic signed [DPROD_W-1:0]  d_reg;
    logic [QPROD_W-1:0]         q_reg;
    logic                       hit_reg;

    // result registers
    logic                 out_valid_reg, out_valid_next;
    logic [BINOUT_W-1:0]  bin_index_reg;
    logic                 in_range_reg;
    logic [COUNT_W-1:0]   bin_count_reg;

    // combinational terms
    logic                 accept;
    logic                 out_free;
    logic                 upd_go;
    logic signed [32:0]   diff;
    logic [63:0]          prod;
    logic signed [63:0]   sq_full;
    logic signed [48:0]   d_full;
    logic                 hit;
    logic [COUNT_W:0]     cnt_add;
    logic [COUNT_W-1:0]   cnt_new;
    logic                 ram_we;
    logic [BIN_W-1:0]     ram_waddr;
    logic [COUNT_W-1:0]   ram_wdata;
    logic [COUNT_W-1:0]   ram_rdata;
    stat_upd_t            upd;
    stat_t                stats;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign upd_go    = (state_reg == ST_UPD) && out_free;

    // Configuration writes; unused index is ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_start_reg <= '0;
            bin_scale_reg <= BIN_SCALE_RST;
            num_bins_reg  <= NUM_BINS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_BIN_START: bin_start_reg <= cfg_data;
                CFG_BIN_SCALE: bin_scale_reg <= cfg_data;
                CFG_NUM_BINS:  num_bins_reg  <= cfg_data[NBINS_W-1:0];
                default: ;
            endcase
        end
    end

    // Control state
    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == BIN_W'(NUM_BINS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:  state_next = ST_READ;
            ST_READ: state_next = ST_UPD;
            ST_UPD:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg <= sample;
            weight_reg <= weight;
        end
    end

    // Multiply stage: bin position, square and weighted sample
    always_comb
    begin
        diff    = {sample_reg[SAMPLE_W-1], sample_reg} - {bin_start_reg[31], bin_start_reg};
        prod    = diff[31:0] * bin_scale_reg;
        sq_full = sample_reg * sample_reg;
        d_full  = sample_reg * $signed({1'b0, weight_reg});
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_MUL)
        begin
            neg_reg <= diff[32];
            bin_reg <= prod[63:32];
            sqq_reg <= sq_full[62:16];
            d_reg   <= d_full[DPROD_W-1:0];
        end
    end

    // Read stage: range check, RAM read, weighted square
    assign hit = !neg_reg && (bin_reg < {{(32 - NBINS_W){1'b0}}, num_bins_reg})
               && (bin_reg < BIN_LIMIT);

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_READ)
        begin
            hit_reg <= hit;
            q_reg   <= sqq_reg * weight_reg;
        end
    end

    // Update stage: saturating bin count
    always_comb
    begin
        cnt_add = {1'b0, ram_rdata} + {{(COUNT_W + 1 - WEIGHT_W){1'b0}}, weight_reg};
        cnt_new = cnt_add[COUNT_W] ? {COUNT_W{1'b1}} : cnt_add[COUNT_W-1:0];
    end

    // RAM write port shared by the clearing pass and the bin update
    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = upd_go && hit_reg;
            ram_waddr = bin_reg[BIN_W-1:0];
            ram_wdata = cnt_new;
        end
    end

    hrs_bin_ram #(
        .DEPTH  (NUM_BINS),
        .ADDR_W (BIN_W)
    ) u_bin_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (state_reg == ST_READ),
        .raddr (bin_reg[BIN_W-1:0]),
        .rdata (ram_rdata)
    );

    // Statistics update
    always_comb
    begin
        upd.en     = upd_go;
        upd.sample = sample_reg;
        upd.weight = weight_reg;
        upd.d_prod = d_reg;
        upd.q_prod = q_reg;
    end

    hrs_stats u_stats (
        .clk   (clk),
        .rst_n (rst_n),
        .upd   (upd),
        .stats (stats)
    );

    // Result register
    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (upd_go)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd_go)
        begin
            bin_index_reg <= hit_reg ? bin_reg[BINOUT_W-1:0] : '0;
            in_range_reg  <= hit_reg;
            bin_count_reg <= hit_reg ? cnt_new : '0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign bin_index  = bin_index_reg;
    assign in_range   = in_range_reg;
    assign bin_count  = bin_count_reg;
    assign item_count = stats.item_count;
    assign value_sum  = stats.value_sum;
    assign square_sum = stats.square_sum;
    assign min_value  = stats.min_value;
    assign max_value  = stats.max_value;

    // Checks
    a_accept_to_mul: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_MUL)
        else $error("accepted item did not enter the multiply stage");

    a_result_from_upd: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_UPD)
        else $error("result appeared outside the update stage");

    a_miss_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !in_range_reg) |-> (bin_index_reg == '0 && bin_count_reg == '0))
        else $error("out-of-range result carries a bin or count");

    a_no_ram_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE || state_reg == ST_MUL || state_reg == ST_READ) |-> !ram_we)
        else $error("bin RAM written outside clear or update");

endmodule

`default_nettype wire

// ===== sim/hrs_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hrs_checker
// Watches the configuration, sample and result channels of the weighted
// histogram. It keeps its own bin counts and running statistics, works out
// the result of every accepted sample and compares each accepted result
// field by field, oldest prediction first.
// ----------------------------------------------------------------------------
module hrs_checker
    import hrs_pkg::*;
#(
    parameter int HIST_BINS = 1024
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [31:0]                cfg_data,
    input  logic                       in_valid,
    input  logic                       in_stall,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic [WEIGHT_W-1:0]        weight,
    input  logic                       out_valid,
    input  logic                       out_stall,
    input  logic [BINOUT_W-1:0]        bin_index,
    input  logic                       in_range,
    input  logic [COUNT_W-1:0]         bin_count,
    input  logic [COUNT_W-1:0]         item_count,
    input  logic signed [SUM_W-1:0]    value_sum,
    input  logic [SQSUM_W-1:0]         square_sum,
    input  logic signed [SAMPLE_W-1:0] min_value,
    input  logic signed [SAMPLE_W-1:0] max_value,
    output int                         pending,
    output int                         errors
);

    // One result item as the block should report it
    typedef struct packed {
        logic [BINOUT_W-1:0] bin_index;
        logic                in_range;
        logic [COUNT_W-1:0]  bin_count;
        stat_t               stats;
    } hist_result_t;

    // Mirrored configuration
    logic signed [31:0]  start_reg;
    logic [31:0]         scale_reg;
    logic [NBINS_W-1:0]  nbins_reg;

    // Mirrored histogram and running statistics
    logic [COUNT_W-1:0]         bin_tally [HIST_BINS];
    logic [COUNT_W-1:0]         weight_acc;
    logic signed [SUM_W-1:0]    value_acc;
    logic [SQSUM_W-1:0]         square_acc;
    logic signed [SAMPLE_W-1:0] low_seen;
    logic signed [SAMPLE_W-1:0] high_seen;

    hist_result_t hist_results_due [$];
    hist_result_t want;
    int           fail_total = 0;

    function automatic logic [COUNT_W-1:0] add_clamp32(input logic [COUNT_W-1:0] a,
                                                       input logic [WEIGHT_W-1:0] b);
        logic [COUNT_W:0] t;
        t = {1'b0, a} + b;
        return t[COUNT_W] ? {COUNT_W{1'b1}} : t[COUNT_W-1:0];
    endfunction

    // Fold one sample into the mirrored state and return its result
    function automatic hist_result_t tally_sample(input logic signed [31:0] s,
                                                  input logic [WEIGHT_W-1:0] w);
        hist_result_t      r;
        longint            offset;
        longint unsigned   off_u;
        longint unsigned   scaled;
        longint unsigned   bin;
        longint            weighted;
        logic signed [64:0] sum_next;
        longint            sq_full;
        longint unsigned   sq_term;
        longint unsigned   sq_next;
        r = '0;

        // bin lookup: exact 33 bit difference, exact Q32.32 product
        offset = longint'(s) - longint'(start_reg);
        if (offset >= 0) begin
            off_u  = offset;
            scaled = off_u * {32'b0, scale_reg};
            bin    = scaled >> 32;
            if (bin < nbins_reg && bin < HIST_BINS) begin
                bin_tally[bin] = add_clamp32(bin_tally[bin], w);
                r.in_range  = 1'b1;
                r.bin_index = bin[BINOUT_W-1:0];
                r.bin_count = bin_tally[bin];
            end
        end

        weight_acc = add_clamp32(weight_acc, w);

        // weighted sum, clamped to signed 64 bit
        weighted = longint'(s) * longint'(w);
        sum_next = $signed({value_acc[63], value_acc}) + $signed({weighted[63], weighted});
        if (sum_next[64] != sum_next[63])
            value_acc = sum_next[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
        else
            value_acc = sum_next[63:0];

        // weighted sum of squares, square truncated back to Q16.16
        sq_full = longint'(s) * longint'(s);
        sq_term = ($unsigned(sq_full) >> 16) * {48'b0, w};
        sq_next = {1'b0, square_acc} + sq_term;
        if (sq_next > {1'b0, SQ_MAX})
            square_acc = SQ_MAX;
        else
            square_acc = sq_next[SQSUM_W-1:0];

        if (s < low_seen)
            low_seen = s;
        if (s > high_seen)
            high_seen = s;

        r.stats.item_count = weight_acc;
        r.stats.value_sum  = value_acc;
        r.stats.square_sum = square_acc;
        r.stats.min_value  = low_seen;
        r.stats.max_value  = high_seen;
        return r;
    endfunction

    task automatic flag_mismatch(input string field, input logic [63:0] exp_val,
                                 input logic [63:0] got_val);
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, exp_val, got_val);
        fail_total++;
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int i = 0; i < HIST_BINS; i++)
                bin_tally[i] = '0;
            weight_acc = '0;
            value_acc  = '0;
            square_acc = '0;
            low_seen   = 32'sh7FFF_FFFF;
            high_seen  = 32'sh8000_0000;
            start_reg  = '0;
            scale_reg  = BIN_SCALE_RST;
            nbins_reg  = NUM_BINS_RST;
            hist_results_due.delete();
            pending <= 0;
        end
        else begin
            // register writes
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_BIN_START: start_reg = cfg_data;
                    CFG_BIN_SCALE: scale_reg = cfg_data;
                    CFG_NUM_BINS:  nbins_reg = cfg_data[NBINS_W-1:0];
                    default:       ;
                endcase
            end

            // result items against the oldest prediction
            if (out_valid && !out_stall) begin
                if (hist_results_due.size() == 0) begin
                    $display("%0t: result item with no prediction waiting", $time);
                    fail_total++;
                end
                else begin
                    want = hist_results_due.pop_front();
                    if (bin_index !== want.bin_index)
                        flag_mismatch("bin_index", want.bin_index, bin_index);
                    if (in_range !== want.in_range)
                        flag_mismatch("in_range", want.in_range, in_range);
                    if (bin_count !== want.bin_count)
                        flag_mismatch("bin_count", want.bin_count, bin_count);
                    if (item_count !== want.stats.item_count)
                        flag_mismatch("item_count", want.stats.item_count, item_count);
                    if (value_sum !== want.stats.value_sum)
                        flag_mismatch("value_sum", want.stats.value_sum, value_sum);
                    if (square_sum !== want.stats.square_sum)
                        flag_mismatch("square_sum", want.stats.square_sum, square_sum);
                    if (min_value !== want.stats.min_value)
                        flag_mismatch("min_value", want.stats.min_value, min_value);
                    if (max_value !== want.stats.max_value)
                        flag_mismatch("max_value", want.stats.max_value, max_value);
                end
            end

            // sample items
            if (in_valid && !in_stall)
                hist_results_due.push_back(tally_sample(sample, weight));

            pending <= hist_results_due.size();
        end
        errors <= fail_total;
    end

endmodule

// ===== sim/histogram_with_running_stats_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// histogram_with_running_stats_top_tb
// Drives samples and register writes into the weighted histogram: a directed
// pass over bin edges, samples below the start, extreme values, zero weight
// and unused register writes, then random phases under random bin settings
// with random idling on both sides, a long result hold-off, and a final run
// into sum-of-squares saturation. The checker beside the block does the
// comparing; this module gives the verdict.
// ----------------------------------------------------------------------------
module histogram_with_running_stats_top_tb;
    import hrs_pkg::*;

    localparam int HIST_BINS      = 1024;
    localparam int SETTLE_CYCLES  = 10;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 240;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 172;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index = '0;
    logic [31:0]                cfg_data  = '0;
    logic                       in_valid  = 1'b0;
    logic                       in_stall;
    logic signed [SAMPLE_W-1:0] sample    = '0;
    logic [WEIGHT_W-1:0]        weight    = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic [BINOUT_W-1:0]        bin_index;
    logic                       in_range;
    logic [COUNT_W-1:0]         bin_count;
    logic [COUNT_W-1:0]         item_count;
    logic signed [SUM_W-1:0]    value_sum;
    logic [SQSUM_W-1:0]         square_sum;
    logic signed [SAMPLE_W-1:0] min_value;
    logic signed [SAMPLE_W-1:0] max_value;

    int pending;
    int errors;

    // stimulus controls
    logic calm      = 1'b0;
    logic hold_req  = 1'b0;
    logic hold_seen = 1'b0;
    int   stall_left = 0;
    int   idle_cycles = 0;

    // settings currently programmed, used to aim samples at the bins
    logic signed [31:0] start_now = '0;
    logic [31:0]        scale_now = BIN_SCALE_RST;
    int                 nbins_now = HIST_BINS;

    always #6 clk = ~clk;

    histogram_with_running_stats_top #(
        .NUM_BINS (HIST_BINS)
    ) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sample     (sample),
        .weight     (weight),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .bin_index  (bin_index),
        .in_range   (in_range),
        .bin_count  (bin_count),
        .item_count (item_count),
        .value_sum  (value_sum),
        .square_sum (square_sum),
        .min_value  (min_value),
        .max_value  (max_value)
    );

    hrs_checker #(
        .HIST_BINS (HIST_BINS)
    ) stats_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sample     (sample),
        .weight     (weight),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .bin_index  (bin_index),
        .in_range   (in_range),
        .bin_count  (bin_count),
        .item_count (item_count),
        .value_sum  (value_sum),
        .square_sum (square_sum),
        .min_value  (min_value),
        .max_value  (max_value),
        .pending    (pending),
        .errors     (errors)
    );

    // Result side: random stalls, one long hold-off on request
    always @(posedge clk) begin
        if (hold_req && !hold_seen) begin
            hold_seen  <= 1'b1;
            stall_left <= HOLD_CYCLES;
            out_stall  <= 1'b1;
        end
        else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end
        else begin
            out_stall <= !calm && ($urandom_range(0, 99) < 26);
        end
    end

    // Watchdog: cycles with no item or write accepted anywhere
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, idle_cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Offer one sample item, with a random gap before it
    task automatic send_item(input logic signed [31:0] s, input logic [WEIGHT_W-1:0] w);
        while (!calm && $urandom_range(0, 99) < 26) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= s;
        weight   <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Stop offering and wait for every predicted result to come out
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write one register; the caller lowers cfg_valid after the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic set_config(input logic signed [31:0] st, input logic [31:0] sc,
                              input int nb);
        wait_drained();
        write_reg(CFG_BIN_START, st);
        write_reg(CFG_BIN_SCALE, sc);
        write_reg(CFG_NUM_BINS, nb);
        cfg_valid <= 1'b0;
        start_now = st;
        scale_now = sc;
        nbins_now = nb;
    endtask

    // Sample mostly aimed at the bins near the active range, some below
    // the start, some anywhere
    function automatic logic signed [31:0] aim_sample();
        longint unsigned span;
        longint          off;
        int              pick;
        pick = $urandom_range(0, 99);
        if (pick < 12)
            return $urandom;
        if (pick < 20)
            off = -longint'($urandom_range(1, 1 << 16));
        else if (scale_now == 0)
            off = $urandom_range(0, 255);
        else begin
            span = $urandom_range(0, nbins_now + 3);
            span = (span << 32) | $urandom;
            off  = span / scale_now;
        end
        return 32'(longint'(start_now) + off);
    endfunction

    // Big samples get small weights so the sum of squares saturates only
    // in the last phase
    function automatic logic [WEIGHT_W-1:0] pick_weight(input logic signed [31:0] s);
        int pick;
        pick = $urandom_range(0, 99);
        if (s >= 32'sh0100_0000 || s < -32'sh0100_0000)
            return WEIGHT_W'($urandom_range(0, 15));
        if (pick < 5)
            return '0;
        if (pick < 10)
            return 16'hFFFF;
        return WEIGHT_W'($urandom_range(0, 65535));
    endfunction

    initial begin
        logic signed [31:0] s;
        logic signed [31:0] st;
        logic [31:0]        sc;
        int                 nb;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: one bin per unit from zero, all bins
        send_item(32'sh0000_0000, 16'd1);
        send_item(32'sh0000_8000, 16'd2);       // same bin back to back
        send_item(32'sh03FF_FFFF, 16'd3);       // last bin
        send_item(32'sh0400_0000, 16'd1);       // one past the last bin
        send_item(32'shFFFF_FFFF, 16'd1);       // just below start
        send_item(32'sh7FFF_FFFF, 16'd0);       // largest sample, zero weight
        send_item(32'sh8000_0000, 16'd0);       // smallest sample, zero weight
        send_item(32'sh0005_8000, 16'hFFFF);
        send_item(32'sh0005_0000, 16'd0);       // in range, count unchanged
        send_item(32'sh0005_FFFF, 16'hFFFF);

        // lowest start, finest scale, single bin
        set_config(32'sh8000_0000, 32'hFFFF_FFFF, 1);
        send_item(32'sh8000_0000, 16'd1);
        send_item(32'sh8000_0001, 16'd1);
        send_item(32'sh8000_0002, 16'd1);       // bin 1, outside one bin
        send_item(32'sh7FFF_FFFF, 16'd1);       // widest difference

        // highest start, zero scale: anything at or above start is bin 0
        set_config(32'sh7FFF_FFFF, 32'h0000_0000, HIST_BINS);
        send_item(32'sh7FFF_FFFF, 16'd1);
        send_item(32'sh7FFF_FFFE, 16'd1);
        send_item(32'sh0000_0000, 16'hFFFF);

        // write to the unused index must change nothing
        wait_drained();
        write_reg(CFG_SPARE, 32'hFFFF_FFFF);
        cfg_valid <= 1'b0;
        send_item(32'sh7FFF_FFFF, 16'd2);

        // quarter-bin scale from 1.0, exact bin edges
        set_config(32'sh0001_0000, 32'h0000_4000, 300);
        send_item(32'sh0001_0000, 16'd7);
        send_item(32'sh0005_0000, 16'd1);
        send_item(32'sh0004_FFFF, 16'd1);

        // random phases under random settings
        for (int ph = 0; ph < PHASES; ph++) begin
            case ($urandom_range(0, 4))
                0:       st = '0;
                1:       st = $urandom_range(0, 1 << 21) - (1 << 20);
                2:       st = $urandom;
                3:       st = 32'sh8000_0000;
                default: st = 32'sh7FFF_FFFF;
            endcase
            case ($urandom_range(0, 4))
                0:       sc = BIN_SCALE_RST;
                1:       sc = '0;
                2:       sc = 32'hFFFF_FFFF;
                3:       sc = $urandom_range(1 << 8, 1 << 20);
                default: sc = $urandom;
            endcase
            case ($urandom_range(0, 3))
                0:       nb = 1;
                1:       nb = HIST_BINS;
                2:       nb = $urandom_range(1, 16);
                default: nb = $urandom_range(1, HIST_BINS);
            endcase
            set_config(st, sc, nb);
            calm <= (ph == 4);
            if (ph == 2)
                hold_req <= 1'b1;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // sender pause until everything is out
                if (ph == 5 && k == PHASE_ITEMS / 2)
                    wait_drained();
                s = aim_sample();
                send_item(s, pick_weight(s));
            end
        end

        // drive the sum of squares into saturation, then keep going
        set_config(32'sh0000_0000, BIN_SCALE_RST, HIST_BINS);
        send_item(32'sh8000_0000, 16'hFFFF);
        send_item(32'sh8000_0000, 16'hFFFF);
        send_item(32'sh7FFF_FFFF, 16'hFFFF);
        send_item(32'sh0001_0000, 16'd1);
        for (int k = 0; k < 4; k++) begin
            s = aim_sample();
            send_item(s, pick_weight(s));
        end

        wait_drained();
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
